[hw/rtl/assert_macros.svh]
// Assertion helper macros for the slab test RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RUCS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RUCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RUCS_ASSERT(lbl, clk, rstn, prop, msg)
`define RUCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/rucs_pkg.sv]
// Shared types and constants for the ray / unit cube slab test.
// No dependencies.
`default_nettype none
package rucs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int THR_W         = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd7;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // one ray word
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [15:0]        body_id;
    } ray_t;

    // one result word
    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_near;
        logic signed [31:0] t_far;
        logic [15:0]        result_body_id;
    } result_t;

    // per-axis control that rides beside the dividers
    typedef struct packed {
        logic par;   // direction counts as parallel
        logic qneg0; // quotient sign, entry plane
        logic qneg1; // quotient sign, exit plane
        logic npos0;
        logic nneg0;
        logic npos1;
        logic nneg1;
    } axis_ctl_t;

    typedef struct packed {
        axis_ctl_t [2:0] ctl;
        logic [15:0]     body_id;
    } side_t;

endpackage
`default_nettype wire

[hw/rtl/rucs_prep.sv]
// Front stage: numerators, magnitudes, parallel detection, registered.
// Uses rucs_pkg.
`default_nettype none
module rucs_prep #(
    parameter int FRAC_BITS = rucs_pkg::FRAC_BITS_DEF,
    parameter int QW        = 48
) (
    input  wire                          clk,
    input  wire rucs_pkg::ray_t          ray,
    input  wire [rucs_pkg::THR_W-1:0]    thr,
    output logic [QW-1:0]                num_mag [6],
    output logic [31:0]                  den_mag [3],
    output rucs_pkg::side_t              side
);
    import rucs_pkg::*;

    localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic [QW-1:0]      num_next [6];
    logic [31:0]        den_next [3];
    side_t              side_next;
    logic [QW-1:0]      num_reg [6];
    logic [31:0]        den_reg [3];
    side_t              side_reg;

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    // per axis: n0 = -1 - o, n1 = 1 - o, |dir|, parallel test
    always_comb
    begin
        logic signed [32:0] n0;
        logic signed [32:0] n1;
        logic [32:0]        a0;
        logic [32:0]        a1;
        logic [32:0]        dm;
        side_next.body_id = ray.body_id;
        for (int k = 0; k < 3; k++)
        begin
            n0 = -ONE - 33'(org[k]);
            n1 = ONE - 33'(org[k]);
            a0 = n0[32] ? 33'(-n0) : n0;
            a1 = n1[32] ? 33'(-n1) : n1;
            dm = dir[k][31] ? 33'(-33'(dir[k])) : 33'(dir[k]);
            num_next[2*k]   = QW'({a0[31:0], {FRAC_BITS{1'b0}}});
            num_next[2*k+1] = QW'({a1[31:0], {FRAC_BITS{1'b0}}});
            den_next[k]     = dm[31:0];
            side_next.ctl[k].par   = (dm == 33'd0) || (dm < 33'(thr));
            side_next.ctl[k].qneg0 = n0[32] ^ dir[k][31];
            side_next.ctl[k].qneg1 = n1[32] ^ dir[k][31];
            side_next.ctl[k].npos0 = !n0[32] && (n0 != 33'sd0);
            side_next.ctl[k].nneg0 = n0[32];
            side_next.ctl[k].npos1 = !n1[32] && (n1 != 33'sd0);
            side_next.ctl[k].nneg1 = n1[32];
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        side_reg <= side_next;
    end

    assign num_mag = num_reg;
    assign den_mag = den_reg;
    assign side    = side_reg;
endmodule
`default_nettype wire

[hw/rtl/rucs_div.sv]
// Pipelined unsigned restoring divider, four quotient bits per stage.
// Uses rucs_pkg for the house import only.
`default_nettype none
module rucs_div #(
    parameter int QW = 48
) (
    input  wire           clk,
    input  wire [QW-1:0]  num,
    input  wire [31:0]    den,
    output logic [QW-1:0] quo
);
    import rucs_pkg::*;

    localparam int BPS = 4;
    localparam int NS  = QW / BPS;

    // per stage: partial remainder, numerator/quotient shift word, divisor
    logic [31:0]   rem_reg [NS];
    logic [QW-1:0] nq_reg  [NS];
    logic [31:0]   den_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [31:0]   rem_in;
        logic [QW-1:0] nq_in;
        logic [31:0]   den_in;
        logic [31:0]   rem_next;
        logic [QW-1:0] nq_next;

        if (s == 0)
        begin : g_first
            assign rem_in = 32'd0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        // four shift/compare/subtract steps
        always_comb
        begin
            logic [32:0] t;
            rem_next = rem_in;
            nq_next  = nq_in;
            for (int b = 0; b < BPS; b++)
            begin
                t       = {rem_next, nq_next[QW-1]};
                nq_next = {nq_next[QW-2:0], 1'b0};
                if (t >= {1'b0, den_in})
                begin
                    t          = t - {1'b0, den_in};
                    nq_next[0] = 1'b1;
                end
                rem_next = t[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            nq_reg[s]  <= nq_next;
            den_reg[s] <= den_in;
        end
    end

    assign quo = nq_reg[NS-1];
endmodule
`default_nettype wire

[hw/rtl/rucs_post.sv]
// Back end: sign, saturation, slab ordering, entry/exit reduction, hit.
// Uses rucs_pkg. Two register stages.
`default_nettype none
module rucs_post #(
    parameter int QW = 48
) (
    input  wire                   clk,
    input  wire [QW-1:0]          quo [6],
    input  wire rucs_pkg::side_t  side,
    output rucs_pkg::result_t     result
);
    import rucs_pkg::*;

    function automatic logic signed [31:0] fix_q(input logic [QW-1:0] q, input logic neg,
                                                 input logic par, input logic npos,
                                                 input logic nneg);
        logic signed [31:0] r;
        if (par)
            r = npos ? Q_MAX : (nneg ? Q_MIN : 32'sd0);
        else if (!neg)
            r = (|q[QW-1:31]) ? Q_MAX : $signed(q[31:0]);
        else if ((|q[QW-1:32]) || (q[31] && (|q[30:0])))
            r = Q_MIN;
        else
            r = $signed((~q[31:0]) + 32'd1);
        return r;
    endfunction

    logic signed [31:0] lo_next [3];
    logic signed [31:0] hi_next [3];
    logic signed [31:0] lo_reg  [3];
    logic signed [31:0] hi_reg  [3];
    logic [15:0]        id_reg;
    result_t            res_next;
    result_t            res_reg;

    // stage A: signed, saturated t values, ordered per axis
    always_comb
    begin
        logic signed [31:0] a;
        logic signed [31:0] b;
        for (int k = 0; k < 3; k++)
        begin
            a = fix_q(quo[2*k], side.ctl[k].qneg0, side.ctl[k].par,
                      side.ctl[k].npos0, side.ctl[k].nneg0);
            b = fix_q(quo[2*k+1], side.ctl[k].qneg1, side.ctl[k].par,
                      side.ctl[k].npos1, side.ctl[k].nneg1);
            lo_next[k] = (a > b) ? b : a;
            hi_next[k] = (a > b) ? a : b;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        id_reg <= side.body_id;
    end

    // stage B: largest entry, smallest exit
    always_comb
    begin
        logic signed [31:0] nr;
        logic signed [31:0] fr;
        nr = lo_reg[0];
        fr = hi_reg[0];
        for (int k = 1; k < 3; k++)
        begin
            if (lo_reg[k] > nr)
                nr = lo_reg[k];
            if (hi_reg[k] < fr)
                fr = hi_reg[k];
        end
        res_next.hit            = (nr <= fr);
        res_next.t_near         = nr;
        res_next.t_far          = fr;
        res_next.result_body_id = id_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
endmodule
`default_nettype wire

[hw/rtl/ray_unit_cube_slab_test_unit.sv]
// Ray against unit cube slab test, top level.
// Data path: the rucs_prep register, the divider pipeline stages, then the rucs_post registers.
// Throughput: one ray per cycle; busy is always low and results are never held.
// Reset: asynchronous active low; clears valid bits and sets the threshold to 7.
// Uses rucs_pkg, rucs_prep, rucs_div, rucs_post, assert_macros.svh.
`default_nettype none
module ray_unit_cube_slab_test_unit #(
    parameter int FRAC_BITS = rucs_pkg::FRAC_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire rucs_pkg::ray_t       ray,
    input  wire                       cfg_we,
    input  wire [rucs_pkg::THR_W-1:0] cfg_wdata,
    output logic                      done,
    output rucs_pkg::result_t         result
);
    import rucs_pkg::*;
`include "assert_macros.svh"

    localparam int QW  = ((32 + FRAC_BITS + 3) / 4) * 4;
    localparam int NS  = QW / 4;
    localparam int LAT = NS + 3;

    logic [THR_W-1:0] thr_reg;
    logic [LAT-1:0]   vld_reg;
    logic             accept;
    logic [QW-1:0]    num_mag [6];
    logic [31:0]      den_mag [3];
    logic [QW-1:0]    quo     [6];
    side_t            side_prep;
    side_t            side_reg [NS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // valid bits beside the data path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    rucs_prep #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_prep (
        .clk     (clk),
        .ray     (ray),
        .thr     (thr_reg),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .side    (side_prep)
    );

    for (genvar d = 0; d < 6; d++)
    begin : g_div
        rucs_div #(.QW(QW)) u_div (
            .clk (clk),
            .num (num_mag[d]),
            .den (den_mag[d/2]),
            .quo (quo[d])
        );
    end

    // control and tag delay matched to the dividers
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_prep;
        for (int s = 1; s < NS; s++)
            side_reg[s] <= side_reg[s-1];
    end

    rucs_post #(.QW(QW)) u_post (
        .clk    (clk),
        .quo    (quo),
        .side   (side_reg[NS-1]),
        .result (result)
    );

    assign done = vld_reg[LAT-1];

    `RUCS_ASSERT(a_latency, clk, rst_n, accept |-> ##LAT done, "result missing")
    `RUCS_ASSERT(a_hit, clk, rst_n, done |-> (result.hit == (result.t_near <= result.t_far)), "bad hit")
    `RUCS_ASSERT(a_no_spurious, clk, rst_n, done |-> $past(vld_reg[LAT-2]), "word without a ray")
endmodule
`default_nettype wire
